>>> sv/sdf_pkg.sv
package sdf_pkg;

	// Default component width of the packed vectors (Q4.16)
	localparam int COMPONENT_WIDTH_DEF = 20;

	localparam int VEC_W   = 60;
	localparam int REST_W  = 20;
	localparam int COEF_W  = 32;
	localparam int FORCE_W = 32;
	localparam int FRAC_W  = 16;

	localparam int IN_TDATA_W  = 264;
	localparam int OUT_TDATA_W = 96;
	localparam int OUT_TUSER_W = 2;

	// tuser bit positions on the result channel
	localparam int TUSER_DEGENERATE = 0;
	localparam int TUSER_SATURATED  = 1;

	localparam logic [COEF_W-1:0] STIFFNESS_RESET = 32'h0001_0000;
	localparam logic [COEF_W-1:0] DAMPING_RESET   = 32'h0000_0000;

	localparam logic [FORCE_W-1:0] FORCE_MAX = 32'h7FFF_FFFF;
	localparam logic [FORCE_W-1:0] FORCE_MIN = 32'h8000_0000;

	typedef enum logic [0:0] {
		REG_STIFFNESS = 1'b0,
		REG_DAMPING   = 1'b1
	} cfg_reg_t;

endpackage

>>> sv/sdf_sqrt.sv
module sdf_sqrt #(
	parameter int RootW    = 21,
	parameter int PayloadW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [2*RootW-1:0]    radicand,
	input  logic [PayloadW-1:0]   in_payload,
	output logic                  out_valid,
	output logic [RootW-1:0]      root,
	output logic [PayloadW-1:0]   out_payload
);

	localparam int RadW = 2 * RootW;
	localparam int RemW = RootW + 2;

	logic                valid_s [RootW];
	logic [RadW-1:0]     rad_s   [RootW];
	logic [RemW-1:0]     rem_s   [RootW];
	logic [RootW-1:0]    root_s  [RootW];
	logic [PayloadW-1:0] pl_s    [RootW];

	// One result bit per stage, two radicand bits brought down each time
	for (genvar i = 0; i < RootW; i++) begin : g_stage
		logic                v_in;
		logic [RadW-1:0]     rad_in;
		logic [RemW-1:0]     rem_in;
		logic [RootW-1:0]    root_in;
		logic [PayloadW-1:0] pl_in;
		logic [RemW:0]       t;
		logic [RemW:0]       trial;

		if (i == 0) begin : g_first
			assign v_in    = in_valid;
			assign rad_in  = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
			assign pl_in   = in_payload;
		end else begin : g_next
			assign v_in    = valid_s[i-1];
			assign rad_in  = rad_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign pl_in   = pl_s[i-1];
		end

		always_comb begin
			t     = {rem_in[RootW:0], rad_in[RadW-1-2*i -: 2]};
			trial = (RemW+1)'({root_in, 2'b01});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i] <= rad_in;
				pl_s[i]  <= pl_in;
				if (t >= trial) begin
					rem_s[i]  <= RemW'(t - trial);
					root_s[i] <= {root_in[RootW-2:0], 1'b1};
				end else begin
					rem_s[i]  <= RemW'(t);
					root_s[i] <= {root_in[RootW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid   = valid_s[RootW-1];
	assign root        = root_s[RootW-1];
	assign out_payload = pl_s[RootW-1];

endmodule

>>> sv/sdf_div.sv
module sdf_div #(
	parameter int NumW     = 42,
	parameter int QuotW    = 22,
	parameter int DenW     = 21,
	parameter int PayloadW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [NumW-1:0]     num,
	input  logic [DenW-1:0]     den,
	input  logic [PayloadW-1:0] in_payload,
	output logic                out_valid,
	output logic [QuotW-1:0]    quot,
	output logic [PayloadW-1:0] out_payload
);

	logic                valid_s [QuotW];
	logic [NumW-1:0]     num_s   [QuotW];
	logic [DenW-1:0]     den_s   [QuotW];
	logic [DenW-1:0]     rem_s   [QuotW];
	logic [QuotW-1:0]    quot_s  [QuotW];
	logic [PayloadW-1:0] pl_s    [QuotW];

	// Restoring division, one quotient bit per stage. The quotient is known to
	// fit QuotW bits, so the bits above start as the partial remainder.
	for (genvar i = 0; i < QuotW; i++) begin : g_stage
		logic                v_in;
		logic [NumW-1:0]     num_in;
		logic [DenW-1:0]     den_in;
		logic [DenW-1:0]     rem_in;
		logic [QuotW-1:0]    quot_in;
		logic [PayloadW-1:0] pl_in;
		logic [DenW:0]       t;

		if (i == 0) begin : g_first
			assign v_in    = in_valid;
			assign num_in  = num;
			assign den_in  = den;
			assign rem_in  = DenW'(num >> QuotW);
			assign quot_in = '0;
			assign pl_in   = in_payload;
		end else begin : g_next
			assign v_in    = valid_s[i-1];
			assign num_in  = num_s[i-1];
			assign den_in  = den_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign quot_in = quot_s[i-1];
			assign pl_in   = pl_s[i-1];
		end

		assign t = {rem_in, num_in[QuotW-1-i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[i] <= num_in;
				den_s[i] <= den_in;
				pl_s[i]  <= pl_in;
				if (t >= {1'b0, den_in}) begin
					rem_s[i]  <= DenW'(t - {1'b0, den_in});
					quot_s[i] <= {quot_in[QuotW-2:0], 1'b1};
				end else begin
					rem_s[i]  <= DenW'(t);
					quot_s[i] <= {quot_in[QuotW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid   = valid_s[QuotW-1];
	assign quot        = quot_s[QuotW-1];
	assign out_payload = pl_s[QuotW-1];

endmodule

>>> sv/spring_damper_force_unit.sv
// Damped spring force kernel: one spring in, one force vector out.
//
// Input stream (s_axis_*): one spring per transfer. tdata carries both endpoint
// positions and velocities (three signed Q4.16 components each) and the rest
// length. Output stream (m_axis_*): the Q16.16 force that endpoint b gains and
// endpoint a loses, with tuser flagging a zero-length spring and any clamped
// component. The user must write the stiffness and damping registers through
// the cfg_* port only while no spring is in flight; the block does not enforce it.
//
// Throughput: one spring per cycle while the skid register is empty. The pipeline
// holds the bit-per-stage square root (LW = component width + 1), the damping
// division (QW = component width + 2) and the final magnitude division (MW bits
// of force magnitude, 55 by default).
//
// Reset clears every valid bit; the registers return to stiffness 1.0 and
// damping 0. When the receiver stalls, the output register holds its transfer
// and the next result drops into a one-entry skid register; only once that is
// full does the pipeline freeze and s_axis_tready fall.
module spring_damper_force_unit #(
	parameter int COMPONENT_WIDTH = sdf_pkg::COMPONENT_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// position_a, position_b, velocity_a, velocity_b (60 each), rest_length (20)
	input  logic [sdf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// force_x, force_y, force_z (32 each)
	output logic [sdf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// degenerate, saturated
	output logic [sdf_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
	input  logic                             cfg_we,
	input  logic [0:0]                       cfg_index,
	input  logic [sdf_pkg::COEF_W-1:0]       cfg_wdata
);

	import sdf_pkg::*;

	localparam int CW   = COMPONENT_WIDTH;
	localparam int DW   = CW + 1;               // separation / relative velocity
	localparam int SW   = 2 * CW + 2;           // squared length
	localparam int DOTW = SW + 1;               // signed dot product
	localparam int LW   = CW + 1;               // length
	localparam int PQW  = CW + 2;               // |dot / L| is below twice |w|
	localparam int PSW  = PQW + 1;
	localparam int EW   = ((LW > REST_W) ? LW : REST_W) + 1;
	localparam int T1W  = EW + COEF_W + 1;
	localparam int T2W  = PSW + COEF_W + 1;
	localparam int MAXT = ((EW - 1) > PQW) ? (EW - 1) : PQW;
	localparam int MW   = MAXT + COEF_W + 1;    // magnitude of m and of r
	localparam int HW   = MW - COEF_W;
	localparam int GW   = CW + HW + FRAC_W + 1;
	localparam int XW   = 3 * CW;

	localparam logic [GW-1:0] POS_LIM = GW'(FORCE_MAX);
	localparam logic [GW-1:0] NEG_LIM = GW'(FORCE_MAX) + GW'(1);

	// ---------------------------------------------------------------- config
	logic [COEF_W-1:0] stiff_q;
	logic [COEF_W-1:0] damp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q <= STIFFNESS_RESET;
			damp_q  <= DAMPING_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_STIFFNESS: stiff_q <= cfg_wdata;
				REG_DAMPING:   damp_q  <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	// Global advance: freeze only when the skid register is occupied
	logic en;
	logic skid_valid_q;

	assign en            = !skid_valid_q;
	assign s_axis_tready = en;

	// ---------------------------------------------------------------- stage 1
	// Unpack components and form d = a - b, w = va - vb
	logic [XW-1:0]              pa_x, pb_x, va_x, vb_x;
	logic [2:0][DW-1:0]         d_c, w_c;
	logic [2:0][CW-1:0]         ca, cb, cva, cvb;

	assign pa_x = XW'(s_axis_tdata[0*VEC_W +: VEC_W]);
	assign pb_x = XW'(s_axis_tdata[1*VEC_W +: VEC_W]);
	assign va_x = XW'(s_axis_tdata[2*VEC_W +: VEC_W]);
	assign vb_x = XW'(s_axis_tdata[3*VEC_W +: VEC_W]);

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			ca[j]  = pa_x[j*CW +: CW];
			cb[j]  = pb_x[j*CW +: CW];
			cva[j] = va_x[j*CW +: CW];
			cvb[j] = vb_x[j*CW +: CW];
			d_c[j] = {ca[j][CW-1], ca[j]} - {cb[j][CW-1], cb[j]};
			w_c[j] = {cva[j][CW-1], cva[j]} - {cvb[j][CW-1], cvb[j]};
		end
	end

	logic               v_s1;
	logic [2:0][DW-1:0] d_s1, w_s1;
	logic [REST_W-1:0]  rest_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= d_c;
			w_s1    <= w_c;
			rest_s1 <= s_axis_tdata[4*VEC_W +: REST_W];
		end
	end

	// ---------------------------------------------------------------- stage 2
	// Squares and component products d*w, one multiplier each
	logic [2:0][2*DW-1:0] sq_c, pr_c;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sq_c[j] = $signed(d_s1[j]) * $signed(d_s1[j]);
			pr_c[j] = $signed(d_s1[j]) * $signed(w_s1[j]);
		end
	end

	logic                 v_s2;
	logic [2:0][2*CW-1:0] sq_s2;
	logic [2:0][2*DW-1:0] pr_s2;
	logic [2:0][DW-1:0]   d_s2;
	logic [REST_W-1:0]    rest_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				sq_s2[j] <= sq_c[j][2*CW-1:0];
			end
			pr_s2   <= pr_c;
			d_s2    <= d_s1;
			rest_s2 <= rest_s1;
		end
	end

	// ---------------------------------------------------------------- stage 3
	logic                   v_s3;
	logic [SW-1:0]          sum_s3;
	logic signed [DOTW-1:0] dot_s3;
	logic [2:0][DW-1:0]     d_s3;
	logic [REST_W-1:0]      rest_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]);
			dot_s3  <= DOTW'($signed(pr_s2[0])) + DOTW'($signed(pr_s2[1]))
				+ DOTW'($signed(pr_s2[2]));
			d_s3    <= d_s2;
			rest_s3 <= rest_s2;
		end
	end

	// ---------------------------------------------------------------- length
	localparam int SQ_PW = DOTW + REST_W + 3 * DW;

	logic               sq_valid;
	logic [LW-1:0]      sq_root;
	logic [SQ_PW-1:0]   sq_pl;
	logic [DOTW-1:0]    sq_dot;
	logic [REST_W-1:0]  sq_rest;
	logic [2:0][DW-1:0] sq_d;

	sdf_sqrt #(
		.RootW    (LW),
		.PayloadW (SQ_PW)
	) u_sqrt (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (v_s3),
		.radicand    (sum_s3),
		.in_payload  ({dot_s3, rest_s3, d_s3}),
		.out_valid   (sq_valid),
		.root        (sq_root),
		.out_payload (sq_pl)
	);

	assign {sq_dot, sq_rest, sq_d} = sq_pl;

	// ---------------------------------------------------------------- stage 4
	// Spring term and magnitude of the dot product
	logic signed [EW-1:0]   ext_c;
	logic signed [T1W-1:0]  t1_c;
	logic                   dneg_c;
	logic [DOTW-1:0]        dabs_c;

	always_comb begin
		ext_c  = $signed(EW'(sq_root)) - $signed(EW'(sq_rest));
		t1_c   = ext_c * $signed({1'b0, stiff_q});
		dneg_c = sq_dot[DOTW-1];
		dabs_c = dneg_c ? (~sq_dot + DOTW'(1)) : sq_dot;
	end

	logic               v_s4;
	logic [T1W-1:0]     t1_s4;
	logic [SW-1:0]      dmag_s4;
	logic               dneg_s4;
	logic [LW-1:0]      len_s4;
	logic [2:0][DW-1:0] d_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s4   <= t1_c;
			dmag_s4 <= dabs_c[SW-1:0];
			dneg_s4 <= dneg_c;
			len_s4  <= sq_root;
			d_s4    <= sq_d;
		end
	end

	// ---------------------------------------------------------------- dot / L
	localparam int D1_PW = T1W + 1 + LW + 3 * DW;

	logic               dv1_valid;
	logic [PQW-1:0]     dv1_quot;
	logic [D1_PW-1:0]   dv1_pl;
	logic [T1W-1:0]     dv1_t1;
	logic               dv1_neg;
	logic [LW-1:0]      dv1_len;
	logic [2:0][DW-1:0] dv1_d;

	sdf_div #(
		.NumW     (SW),
		.QuotW    (PQW),
		.DenW     (LW),
		.PayloadW (D1_PW)
	) u_div_dot (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (v_s4),
		.num         (dmag_s4),
		.den         (len_s4),
		.in_payload  ({t1_s4, dneg_s4, len_s4, d_s4}),
		.out_valid   (dv1_valid),
		.quot        (dv1_quot),
		.out_payload (dv1_pl)
	);

	assign {dv1_t1, dv1_neg, dv1_len, dv1_d} = dv1_pl;

	// ---------------------------------------------------------------- stage 5
	// Damping term
	logic signed [PSW-1:0] p_c;
	logic signed [T2W-1:0] t2_c;

	always_comb begin
		p_c  = dv1_neg ? -$signed({1'b0, dv1_quot}) : $signed({1'b0, dv1_quot});
		t2_c = p_c * $signed({1'b0, damp_q});
	end

	logic               v_s5;
	logic [T1W-1:0]     t1_s5;
	logic [T2W-1:0]     t2_s5;
	logic [LW-1:0]      len_s5;
	logic [2:0][DW-1:0] d_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s5  <= dv1_t1;
			t2_s5  <= t2_c;
			len_s5 <= dv1_len;
			d_s5   <= dv1_d;
		end
	end

	// ---------------------------------------------------------------- stage 6
	// Total magnitude m, split into sign and size
	logic signed [MW:0] m_c;
	logic [MW:0]        mabs_c;

	always_comb begin
		m_c    = $signed(t1_s5) + $signed(t2_s5);
		mabs_c = m_c[MW] ? (~m_c + (MW+1)'(1)) : m_c;
	end

	logic               v_s6;
	logic [MW-1:0]      mmag_s6;
	logic               mneg_s6;
	logic               degen_s6;
	logic [LW-1:0]      len_s6;
	logic [2:0][DW-1:0] d_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mmag_s6  <= mabs_c[MW-1:0];
			mneg_s6  <= m_c[MW];
			degen_s6 <= (len_s5 == '0);
			len_s6   <= len_s5;
			d_s6     <= d_s5;
		end
	end

	// ---------------------------------------------------------------- m / L
	localparam int D2_PW = 2 + 3 * DW;

	logic               dv2_valid;
	logic [MW-1:0]      dv2_quot;
	logic [D2_PW-1:0]   dv2_pl;
	logic               dv2_neg;
	logic               dv2_degen;
	logic [2:0][DW-1:0] dv2_d;

	sdf_div #(
		.NumW     (MW),
		.QuotW    (MW),
		.DenW     (LW),
		.PayloadW (D2_PW)
	) u_div_mag (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (v_s6),
		.num         (mmag_s6),
		.den         (len_s6),
		.in_payload  ({mneg_s6, degen_s6, d_s6}),
		.out_valid   (dv2_valid),
		.quot        (dv2_quot),
		.out_payload (dv2_pl)
	);

	assign {dv2_neg, dv2_degen, dv2_d} = dv2_pl;

	// ---------------------------------------------------------------- stage 7
	// Scale each |d| by r in two partial products (high and low word of r)
	logic                      rneg_c;
	logic [2:0][CW-1:0]        dm_c;
	logic [2:0][DW-1:0]        dneg_abs_c;

	always_comb begin
		rneg_c = dv2_neg && (dv2_quot != '0);
		for (int j = 0; j < 3; j++) begin
			dneg_abs_c[j] = dv2_d[j][DW-1] ? (~dv2_d[j] + DW'(1)) : dv2_d[j];
			dm_c[j]       = dneg_abs_c[j][CW-1:0];
		end
	end

	logic                       v_s7;
	logic [2:0][CW+HW-1:0]      ph_s7;
	logic [2:0][CW+COEF_W-1:0]  pl_s7;
	logic [2:0]                 neg_s7;
	logic                       degen_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= dv2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				ph_s7[j]  <= dm_c[j] * dv2_quot[MW-1:COEF_W];
				pl_s7[j]  <= dm_c[j] * dv2_quot[COEF_W-1:0];
				neg_s7[j] <= dv2_d[j][DW-1] ^ rneg_c;
			end
			degen_s7 <= dv2_degen;
		end
	end

	// ---------------------------------------------------------------- stage 8
	// Recombine, apply sign, clamp to Q16.16, force zero for a zero-length spring
	logic [2:0][GW-1:0]      mag_c;
	logic [2:0]              sat_c;
	logic [2:0][FORCE_W-1:0] f_c;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mag_c[j] = (GW'(ph_s7[j]) << FRAC_W) + GW'(pl_s7[j] >> FRAC_W);
			sat_c[j] = neg_s7[j] ? (mag_c[j] > NEG_LIM) : (mag_c[j] > POS_LIM);
			if (degen_s7) begin
				f_c[j] = '0;
			end else if (sat_c[j]) begin
				f_c[j] = neg_s7[j] ? FORCE_MIN : FORCE_MAX;
			end else if (neg_s7[j]) begin
				f_c[j] = FORCE_W'(~mag_c[j] + GW'(1));
			end else begin
				f_c[j] = FORCE_W'(mag_c[j]);
			end
		end
	end

	logic                    v_s8;
	logic [2:0][FORCE_W-1:0] f_s8;
	logic                    degen_s8;
	logic                    sat_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s8     <= f_c;
			degen_s8 <= degen_s7;
			sat_s8   <= (|sat_c) && !degen_s7;
		end
	end

	// ---------------------------------------------------------------- output
	// Output register plus one skid entry; the skid fills only while the
	// receiver holds off, and freezes the pipeline until it drains.
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [OUT_TUSER_W-1:0] out_user_q;
	logic [OUT_TDATA_W-1:0] skid_data_q;
	logic [OUT_TUSER_W-1:0] skid_user_q;
	logic [OUT_TDATA_W-1:0] res_data;
	logic [OUT_TUSER_W-1:0] res_user;
	logic                   out_free;
	logic                   load_out;
	logic                   load_skid;
	logic                   move_skid;

	always_comb begin
		res_data                   = {f_s8[2], f_s8[1], f_s8[0]};
		res_user                   = '0;
		res_user[TUSER_DEGENERATE] = degen_s8;
		res_user[TUSER_SATURATED]  = sat_s8;
		out_free                   = !out_valid_q || m_axis_tready;
		move_skid                  = skid_valid_q && m_axis_tready;
		load_out                   = en && v_s8 && out_free;
		load_skid                  = en && v_s8 && !out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (move_skid || load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (move_skid) begin
				skid_valid_q <= 1'b0;
			end else if (load_skid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_skid) begin
			out_data_q <= skid_data_q;
			out_user_q <= skid_user_q;
		end else if (load_out) begin
			out_data_q <= res_data;
			out_user_q <= res_user;
		end
		if (load_skid) begin
			skid_data_q <= res_data;
			skid_user_q <= res_user;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

>>> sv/sdf_checker.sv
module sdf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [sdf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic [sdf_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);

	import sdf_pkg::*;

	logic [FORCE_W-1:0] fx, fy, fz;

	assign fx = m_axis_tdata[0*FORCE_W +: FORCE_W];
	assign fy = m_axis_tdata[1*FORCE_W +: FORCE_W];
	assign fz = m_axis_tdata[2*FORCE_W +: FORCE_W];

	// Nothing leaves the block once reset has taken hold
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("result valid during reset");

	// A zero-length spring gives a zero force and no clamp
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[TUSER_DEGENERATE]
		|-> m_axis_tdata == '0 && !m_axis_tuser[TUSER_SATURATED])
		else $error("degenerate result carries a force");

	// A clamp leaves at least one component at a rail
	a_saturated_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[TUSER_SATURATED]
		|-> fx == FORCE_MAX || fx == FORCE_MIN || fy == FORCE_MAX
			|| fy == FORCE_MIN || fz == FORCE_MAX || fz == FORCE_MIN)
		else $error("saturated flag without a clamped component");

	// Input back-pressure only appears behind a stalled result
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result waiting");

	// A stalled transfer holds its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready
		|=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

endmodule

bind spring_damper_force_unit sdf_checker u_sdf_checker (.*);
